[design/pwmcap_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pwmcap_pkg
// Shared widths, codes and reset values for the pwm capture measurement core.
// ----------------------------------------------------------------------------
package pwmcap_pkg;

    localparam int STAMP_BITS_DEF = 16;
    localparam int STAMP_IN_W     = 16;
    localparam int TICK_W         = 24;
    localparam int DUTY_W         = 7;
    localparam int TICKS_OUT_W    = 16;
    localparam int PHASE_W        = 2;

    // result fields: done, duty, frequency, high, low, error, watch edge, phase
    localparam int RES_W      = 1 + DUTY_W + TICK_W + 2 * TICKS_OUT_W + 1 + 1 + PHASE_W;
    localparam int M_TDATA_W  = ((RES_W + 7) / 8) * 8;

    localparam int unsigned PERCENT_SCALE   = 100;
    localparam logic [TICK_W-1:0] TICK_RATE_RESET = 24'd1000000;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_CAPTURE = 1'b1;

    localparam logic [PHASE_W-1:0] PH_ARMED = 2'd0;
    localparam logic [PHASE_W-1:0] PH_RISE  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_FALL  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DONE  = 2'd3;

endpackage : pwmcap_pkg
`default_nettype wire

[design/pwm_capture_duty_frequency_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_capture_duty_frequency_core
// PWM duty and frequency measurement from rising, falling, rising capture
// stamps.
// ----------------------------------------------------------------------------
// Every input transaction gives one result transaction. A start command
// (tuser 0) re-arms the block; captures (tuser 1) are taken as rising,
// falling, rising. Start commands and the first two captures go straight to
// the output state. The third capture runs a multiply by 100 and then two
// divisions on one shared restoring divider that produces one quotient bit
// per cycle. A zero period skips the multiply and the divisions. s_tready is
// low while an item is being worked on; a finished result sits in the output
// register, so the next item can be taken while it waits.
// The tick rate register may only be written while the block is idle.
// ----------------------------------------------------------------------------
module pwm_capture_duty_frequency_core #(
    parameter int STAMP_BITS = pwmcap_pkg::STAMP_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [15:0] capture_stamp
    input  wire logic [pwmcap_pkg::STAMP_IN_W-1:0]   s_tdata,
    // [0] opcode
    input  wire logic                                s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [0] measure_done, [7:1] duty_percent, [31:8] frequency_hz,
    // [47:32] high_ticks, [63:48] low_ticks, [64] period_zero_error,
    // [65] watch_rising_edge, [67:66] capture_phase, [71:68] zero
    output logic [pwmcap_pkg::M_TDATA_W-1:0]         m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pwmcap_pkg::TICK_W-1:0]       cfg_data
);

    import pwmcap_pkg::*;

    localparam int SW     = STAMP_BITS;
    localparam int EW     = (SW > STAMP_IN_W) ? SW : STAMP_IN_W;
    localparam int PW     = SW + 1;
    localparam int PROD_W = SW + DUTY_W;
    localparam int NW     = (PROD_W > TICK_W) ? PROD_W : TICK_W;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_MUL       = 3'd1;
    localparam logic [2:0] ST_DUTY_GO   = 3'd2;
    localparam logic [2:0] ST_DUTY_WAIT = 3'd3;
    localparam logic [2:0] ST_FREQ_GO   = 3'd4;
    localparam logic [2:0] ST_FREQ_WAIT = 3'd5;
    localparam logic [2:0] ST_OUT       = 3'd6;

    logic [2:0]           state_reg,  state_next;
    logic [PHASE_W-1:0]   phase_reg,  phase_next;
    logic [TICK_W-1:0]    tick_rate_reg;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic [SW-1:0]        rise_stamp_reg, fall_stamp_reg;
    logic [SW-1:0]        hi_reg, lo_reg;
    logic [PW-1:0]        period_reg;
    logic [NW-1:0]        prod_reg;
    logic                 done_reg, err_reg;
    logic [DUTY_W-1:0]    duty_reg;
    logic [TICK_W-1:0]    freq_reg;

    logic                 in_accept;
    logic                 out_load;
    logic [SW-1:0]        stamp_w, hi_w, lo_w;
    logic [PW-1:0]        period_w;
    logic                 div_start, div_done;
    logic [NW-1:0]        div_num, div_quot;
    logic                 watch_rise;
    logic [RES_W-1:0]     res_w;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    assign stamp_w  = SW'(EW'(s_tdata));
    assign hi_w     = fall_stamp_reg - rise_stamp_reg;
    assign lo_w     = stamp_w - fall_stamp_reg;
    assign period_w = PW'(hi_w) + PW'(lo_w);

    assign div_start = (state_reg == ST_DUTY_GO) || (state_reg == ST_FREQ_GO);
    assign div_num   = (state_reg == ST_DUTY_GO) ? prod_reg : NW'(tick_rate_reg);

    pwmcap_div #(
        .NUM_W (NW),
        .DEN_W (PW)
    ) u_div (
        .clk   (aclk),
        .rst_n (aresetn),
        .start (div_start),
        .num   (div_num),
        .den   (period_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_OUT;
                    if (s_tuser == OP_START) begin
                        phase_next = PH_ARMED;
                    end else begin
                        unique case (phase_reg)
                            PH_ARMED: phase_next = PH_RISE;
                            PH_RISE:  phase_next = PH_FALL;
                            PH_FALL: begin
                                phase_next = PH_DONE;
                                if (period_w != '0) begin
                                    state_next = ST_MUL;
                                end
                            end
                            default:  phase_next = phase_reg;
                        endcase
                    end
                end
            end
            ST_MUL:       state_next = ST_DUTY_GO;
            ST_DUTY_GO:   state_next = ST_DUTY_WAIT;
            ST_DUTY_WAIT: if (div_done) state_next = ST_FREQ_GO;
            ST_FREQ_GO:   state_next = ST_FREQ_WAIT;
            ST_FREQ_WAIT: if (div_done) state_next = ST_OUT;
            ST_OUT:       if (out_load) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_ARMED;
            tick_rate_reg <= TICK_RATE_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (cfg_valid && cfg_ready) begin
                tick_rate_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // measurement datapath
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            done_reg <= 1'b0;
            err_reg  <= 1'b0;
            duty_reg <= '0;
            freq_reg <= '0;
            hi_reg   <= '0;
            lo_reg   <= '0;
            if (s_tuser == OP_CAPTURE) begin
                case (phase_reg)
                    PH_ARMED: rise_stamp_reg <= stamp_w;
                    PH_RISE:  fall_stamp_reg <= stamp_w;
                    PH_FALL: begin
                        done_reg   <= 1'b1;
                        err_reg    <= (period_w == '0);
                        hi_reg     <= hi_w;
                        lo_reg     <= lo_w;
                        period_reg <= period_w;
                    end
                    default: ;
                endcase
            end
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= NW'(hi_reg) * NW'(PERCENT_SCALE);
        end
        if (state_reg == ST_DUTY_WAIT && div_done) begin
            duty_reg <= DUTY_W'(div_quot);
        end
        if (state_reg == ST_FREQ_WAIT && div_done) begin
            freq_reg <= TICK_W'(div_quot);
        end
        if (out_load) begin
            m_data_reg <= {{(M_TDATA_W - RES_W){1'b0}}, res_w};
        end
    end

    // every phase but the rise phase watches a rising edge; a finished phase watches it for the next measurement
    assign watch_rise = (phase_reg != PH_RISE);

    assign res_w = {phase_reg, watch_rise, err_reg,
                    TICKS_OUT_W'(EW'(lo_reg)), TICKS_OUT_W'(EW'(hi_reg)),
                    freq_reg, duty_reg, done_reg};

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule : pwm_capture_duty_frequency_core
`default_nettype wire

[design/pwmcap_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pwmcap_div
// Restoring unsigned divider, one quotient bit per cycle, shared by the duty
// and frequency computations.
// ----------------------------------------------------------------------------
module pwmcap_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 17
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg,  busy_next;
    logic             done_reg,  done_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [NUM_W-1:0] num_reg,   num_next;
    logic [DEN_W-1:0] rem_reg,   rem_next;
    logic [DEN_W-1:0] den_reg,   den_next;

    logic [DEN_W:0]   rem_shift;
    logic             fits;

    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            num_next  = num;
            rem_next  = '0;
            den_next  = den;
        end else if (busy_reg) begin
            // quotient bits shift in where the dividend bits leave
            num_next = {num_reg[NUM_W-2:0], fits};
            rem_next = fits ? DEN_W'(rem_shift - {1'b0, den_reg}) : rem_shift[DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule : pwmcap_div
`default_nettype wire

[bench/tb_pwm_capture_duty_frequency_core.sv]
// ----------------------------------------------------------------------------
// tb_pwm_capture_duty_frequency_core
// Self-checking bench for the pwm duty and frequency capture core. It drives
// start and capture transactions with bursty timing, stalls the result side on
// its own pattern, and checks every result against a cycle-free model of the
// capture sequence. The tick rate is changed between phases while idle.
// ----------------------------------------------------------------------------
module tb_pwm_capture_duty_frequency_core;
    import pwmcap_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 60;
    localparam int PHASE_ITEMS  = 88;
    localparam int NUM_RATES    = 6;

    typedef struct packed {
        logic [M_TDATA_W-RES_W-1:0] pad;
        logic [PHASE_W-1:0]         phase;
        logic                       watch_rise;
        logic                       zero_period;
        logic [TICKS_OUT_W-1:0]     low_ticks;
        logic [TICKS_OUT_W-1:0]     high_ticks;
        logic [TICK_W-1:0]          freq;
        logic [DUTY_W-1:0]          duty;
        logic                       done;
    } pwm_result_t;

    // tracks the capture sequence and holds the results still owed
    class pwm_measurement_tracker;
        logic [TICK_W-1:0]     tick_rate;
        logic [PHASE_W-1:0]    phase;
        logic [STAMP_IN_W-1:0] rise_stamp;
        logic [STAMP_IN_W-1:0] fall_stamp;
        pwm_result_t           owed_results[$];
        int unsigned           mismatches;
        int unsigned           results_checked;
        int unsigned           starts;
        int unsigned           ignored_captures;
        int unsigned           measurements;
        int unsigned           zero_periods;
        int unsigned           full_duty;

        function new();
            tick_rate  = TICK_RATE_RESET;
            phase      = PH_ARMED;
            rise_stamp = '0;
            fall_stamp = '0;
        endfunction

        function void set_tick_rate(logic [TICK_W-1:0] rate);
            tick_rate = rate;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function void accept_item(logic op, logic [STAMP_IN_W-1:0] stamp);
            pwm_result_t r;
            logic [31:0] period;
            r = '0;
            if (op == OP_START) begin
                phase = PH_ARMED;
                starts++;
            end else begin
                case (phase)
                    PH_ARMED: begin
                        rise_stamp = stamp;
                        phase = PH_RISE;
                    end
                    PH_RISE: begin
                        fall_stamp = stamp;
                        phase = PH_FALL;
                    end
                    PH_FALL: begin
                        r.high_ticks = fall_stamp - rise_stamp;
                        r.low_ticks  = stamp - fall_stamp;
                        period = 32'(r.high_ticks) + 32'(r.low_ticks);
                        if (period == 0) begin
                            r.zero_period = 1'b1;
                            zero_periods++;
                        end else begin
                            r.duty = DUTY_W'((32'(r.high_ticks) * PERCENT_SCALE) / period);
                            r.freq = TICK_W'(32'(tick_rate) / period);
                            if (r.low_ticks == 0)
                                full_duty++;
                        end
                        r.done = 1'b1;
                        phase = PH_DONE;
                        measurements++;
                    end
                    default: begin
                        ignored_captures++;
                    end
                endcase
            end
            r.watch_rise = (phase != PH_RISE);
            r.phase      = phase;
            owed_results.push_back(r);
        endfunction

        function void compare(string field, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch in %s of result %0d: expected %0h, got %0h",
                             field, results_checked, exp_v, act_v);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] word);
            pwm_result_t got;
            pwm_result_t want;
            got = pwm_result_t'(word);
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction, data %0h", word);
                return;
            end
            want = owed_results.pop_front();
            compare("measure_done", 32'(want.done), 32'(got.done));
            compare("duty_percent", 32'(want.duty), 32'(got.duty));
            compare("frequency_hz", 32'(want.freq), 32'(got.freq));
            compare("high_ticks", 32'(want.high_ticks), 32'(got.high_ticks));
            compare("low_ticks", 32'(want.low_ticks), 32'(got.low_ticks));
            compare("period_zero_error", 32'(want.zero_period), 32'(got.zero_period));
            compare("watch_rising_edge", 32'(want.watch_rise), 32'(got.watch_rise));
            compare("capture_phase", 32'(want.phase), 32'(got.phase));
            compare("padding", 32'(want.pad), 32'(got.pad));
            results_checked++;
        endfunction

        function void close_out();
            if (owed_results.size() != 0) begin
                mismatches += owed_results.size();
                $display("%0d results never arrived", owed_results.size());
            end
        endfunction
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [STAMP_IN_W-1:0]    s_tdata;
    logic                     s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_TDATA_W-1:0]     m_tdata;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [TICK_W-1:0]        cfg_data;

    pwm_measurement_tracker   tracker;
    int unsigned              items_sent;
    int unsigned              burst_left;
    bit                       gaps_on = 1'b1;
    int unsigned              hold_calls;
    int unsigned              idle_cycles;
    int unsigned              rate_writes;

    pwm_capture_duty_frequency_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // offer one transaction, with a random gap, possibly none, whenever a burst runs out
    task automatic send_item(logic op, logic [STAMP_IN_W-1:0] stamp);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (!gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= stamp;
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        tracker.accept_item(op, stamp);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_tick_rate(logic [TICK_W-1:0] rate);
        cfg_valid <= 1'b1;
        cfg_data  <= rate;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        tracker.set_tick_rate(rate);
        rate_writes++;
    endtask

    function automatic logic [STAMP_IN_W-1:0] pick_span();
        case ($urandom_range(0, 3))
            0:       return STAMP_IN_W'($urandom_range(0, 3));
            1:       return STAMP_IN_W'($urandom_range(0, 1000));
            2:       return STAMP_IN_W'($urandom);
            default: return STAMP_IN_W'($urandom_range(50, 5000));
        endcase
    endfunction

    // mostly complete start/rise/fall/rise sequences, some cut short, some noise
    task automatic run_random(int unsigned n);
        int unsigned goal;
        int unsigned roll;
        int unsigned extra;
        logic [STAMP_IN_W-1:0] t0, t1, t2;
        goal = items_sent + n;
        while (items_sent < goal) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                t0 = STAMP_IN_W'($urandom);
                if ($urandom_range(0, 11) == 0) begin
                    t1 = t0;
                    t2 = t0;
                end else begin
                    t1 = t0 + pick_span();
                    t2 = t1 + pick_span();
                end
                send_item(OP_START, STAMP_IN_W'($urandom));
                send_item(OP_CAPTURE, t0);
                send_item(OP_CAPTURE, t1);
                send_item(OP_CAPTURE, t2);
                extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
                repeat (extra) send_item(OP_CAPTURE, STAMP_IN_W'($urandom));
            end else if (roll < 85) begin
                send_item(OP_START, STAMP_IN_W'($urandom));
                repeat ($urandom_range(1, 2)) send_item(OP_CAPTURE, STAMP_IN_W'($urandom));
            end else begin
                send_item(1'($urandom), STAMP_IN_W'($urandom));
            end
        end
    endtask

    // result side: own stall pattern plus an occasional long hold-off
    initial begin
        int unsigned rx_cycle;
        int unsigned hold_seen;
        int unsigned hold_left;
        rx_cycle  = 0;
        hold_seen = 0;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            rx_cycle++;
            if (hold_seen != hold_calls) begin
                hold_seen = hold_calls;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case ((rx_cycle / 97) % 4)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom);
                    2:       m_tready <= ($urandom_range(0, 4) == 0);
                    default: m_tready <= (rx_cycle % 3 != 0);
                endcase
            end
        end
    end

    // outputs are stable mid-cycle, so sample the handshakes on the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("no transaction for %0d cycles", IDLE_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        logic [STAMP_IN_W:0] directed_items[23];
        logic [TICK_W-1:0]   rates[NUM_RATES];
        // {opcode, stamp}: captures straight out of reset, zero period, wrap,
        // full and zero duty, longest period, restart mid-sequence
        directed_items = '{
            {OP_CAPTURE, 16'h0000}, {OP_CAPTURE, 16'h0000}, {OP_CAPTURE, 16'h0000},
            {OP_CAPTURE, 16'h1234},
            {OP_START,   16'h0000}, {OP_CAPTURE, 16'hFFFF}, {OP_CAPTURE, 16'h0001},
            {OP_CAPTURE, 16'h0001},
            {OP_START,   16'h0000}, {OP_CAPTURE, 16'h0000}, {OP_CAPTURE, 16'h0000},
            {OP_CAPTURE, 16'hFFFF},
            {OP_START,   16'hFFFF}, {OP_CAPTURE, 16'h0000}, {OP_CAPTURE, 16'hFFFF},
            {OP_CAPTURE, 16'hFFFE},
            {OP_START,   16'h0000}, {OP_CAPTURE, 16'hAAAA}, {OP_START,   16'h5555},
            {OP_CAPTURE, 16'h5555}, {OP_CAPTURE, 16'h5556}, {OP_CAPTURE, 16'h5557},
            {OP_START,   16'hFFFF}
        };
        rates = '{24'd0, 24'd1, 24'd16000000, 24'hFFFFFF,
                  TICK_W'($urandom_range(1, 16000000)), TICK_RATE_RESET};

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= OP_START;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        tracker = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_items[i])
            send_item(directed_items[i][STAMP_IN_W], directed_items[i][STAMP_IN_W-1:0]);
        drain();

        for (int p = 0; p < NUM_RATES; p++) begin
            write_tick_rate(rates[p]);
            if (p == 2) begin
                // long receiver hold-off while items keep coming back to back
                gaps_on = 1'b0;
                hold_calls++;
                run_random(PHASE_ITEMS);
                gaps_on = 1'b1;
            end else if (p == 4) begin
                run_random(PHASE_ITEMS / 2);
                drain();
                run_random(PHASE_ITEMS / 2);
            end else begin
                run_random(PHASE_ITEMS);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        tracker.close_out();
        $display("covered %0d items: %0d starts, %0d measurements (%0d zero period, %0d full duty)",
                 items_sent, tracker.starts, tracker.measurements, tracker.zero_periods,
                 tracker.full_duty);
        $display("%0d captures ignored after completion, %0d tick rate writes, %0d results checked",
                 tracker.ignored_captures, rate_writes, tracker.results_checked);
        if (tracker.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", tracker.mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[pwm_capture_duty_frequency_core.f]
design/pwmcap_pkg.sv
design/pwmcap_div.sv
design/pwm_capture_duty_frequency_core.sv
bench/tb_pwm_capture_duty_frequency_core.sv
